// ----- hw/rtl/swdik_pkg.sv -----
// Shared types, constants and the arctangent table for the swerve drive kinematics block.
`default_nettype none

package swdik_pkg;

    localparam int WHEEL_COUNT = 2;
    localparam int FRONT = 0;
    localparam int REAR = 1;

    localparam int VEL_W = 16;
    localparam int OFF_W = 12;
    localparam int Q_SHIFT = 12;
    localparam int PROD_W = VEL_W + OFF_W;
    localparam int CFG_W = 16;
    localparam int CW = 31;
    localparam int MAG_W = CW - 1;
    localparam int ACC_W = 32;
    localparam int ATAN_LEN = 24;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int RADIUS_W = 16;
    localparam int GAIN_W = 16;
    localparam int PRODM_W = MAG_W + GAIN_W;
    localparam int SPEED_SHIFT = 20;

    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ANGLE_ROUND = 32'h0000_8000;
    localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
    localparam logic [PRODM_W-1:0] SPEED_ROUND = PRODM_W'(1) << (SPEED_SHIFT - 1);

    localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [2:0] {
        CFG_FRONT_X    = 3'd0,
        CFG_FRONT_Y    = 3'd1,
        CFG_REAR_X     = 3'd2,
        CFG_REAR_Y     = 3'd3,
        CFG_INV_RADIUS = 3'd4
    } cfg_index_t;

    typedef logic signed [OFF_W-1:0] offset_t;

    typedef struct packed {
        offset_t x;
        offset_t y;
    } wheel_pos_t;

    typedef wheel_pos_t [WHEEL_COUNT-1:0] geom_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
    } cmd_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] front_angle;
        logic [SPEED_W-1:0] front_speed;
        logic [ANGLE_W-1:0] rear_angle;
        logic [SPEED_W-1:0] rear_speed;
        logic               speed_clipped;
    } result_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } comp_t;

    typedef comp_t [WHEEL_COUNT-1:0] comp_row_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ACC_W-1:0]     acc;
        logic                 zero;
    } vec_t;

    typedef vec_t [WHEEL_COUNT-1:0] vec_row_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swdik_prep.sv -----
// Front end: wheel velocity vectors in Q12 mm/s, then zero test and half-turn fold.
`default_nettype none

module swdik_prep (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire swdik_pkg::cmd_t     up_data,
    input  wire swdik_pkg::geom_t    geom,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output swdik_pkg::vec_row_t      dn_data
);
    import swdik_pkg::*;

    logic      comp_valid_reg;
    logic      comp_ready;
    comp_row_t comp_reg;
    comp_row_t comp_next;

    logic      fold_valid_reg;
    vec_row_t  fold_reg;
    vec_row_t  fold_next;

    logic signed [PROD_W-1:0] prod_x [WHEEL_COUNT];
    logic signed [PROD_W-1:0] prod_y [WHEEL_COUNT];
    logic signed [CW-1:0]     vx_q;
    logic signed [CW-1:0]     vy_q;

    // Stage one: each component is v * 4096 plus or minus yaw rate times offset.
    always_comb begin
        vx_q = {{(CW-VEL_W-Q_SHIFT){up_data.vel_x[VEL_W-1]}}, up_data.vel_x, Q_SHIFT'(0)};
        vy_q = {{(CW-VEL_W-Q_SHIFT){up_data.vel_y[VEL_W-1]}}, up_data.vel_y, Q_SHIFT'(0)};
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            prod_x[w] = PROD_W'(up_data.yaw_rate) * PROD_W'(geom[w].x);
            prod_y[w] = PROD_W'(up_data.yaw_rate) * PROD_W'(geom[w].y);
            comp_next[w].x = vx_q - {{(CW-PROD_W){prod_y[w][PROD_W-1]}}, prod_y[w]};
            comp_next[w].y = vy_q + {{(CW-PROD_W){prod_x[w][PROD_W-1]}}, prod_x[w]};
        end
    end

    assign up_ready = !comp_valid_reg || comp_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_valid_reg <= 1'b0;
        end else if (up_ready) begin
            comp_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            comp_reg <= comp_next;
        end
    end

    // Stage two: zero test, and a vector in the left half plane is turned by half a turn first.
    always_comb begin
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            fold_next[w].zero = (comp_reg[w].x == '0) && (comp_reg[w].y == '0);
            if (comp_reg[w].x[CW-1]) begin
                fold_next[w].x   = -comp_reg[w].x;
                fold_next[w].y   = -comp_reg[w].y;
                fold_next[w].acc = HALF_TURN;
            end else begin
                fold_next[w].x   = comp_reg[w].x;
                fold_next[w].y   = comp_reg[w].y;
                fold_next[w].acc = '0;
            end
        end
    end

    assign comp_ready = !fold_valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (comp_ready) begin
            fold_valid_reg <= comp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (comp_valid_reg && comp_ready) begin
            fold_reg <= fold_next;
        end
    end

    assign dn_valid = fold_valid_reg;
    assign dn_data  = fold_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/swdik_cordic_cell.sv -----
// One vectoring CORDIC iteration for every wheel, with its own item register.
`default_nettype none

module swdik_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire swdik_pkg::vec_row_t up_data,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output swdik_pkg::vec_row_t      dn_data
);
    import swdik_pkg::*;

    logic     valid_reg;
    vec_row_t data_reg;
    vec_row_t data_next;

    logic signed [CW-1:0] dx [WHEEL_COUNT];
    logic signed [CW-1:0] dy [WHEEL_COUNT];

    // Rotate toward the positive x axis; a zero y counts as non-negative.
    always_comb begin
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            dx[w] = up_data[w].y >>> STAGE;
            dy[w] = up_data[w].x >>> STAGE;
            data_next[w].zero = up_data[w].zero;
            if (!up_data[w].y[CW-1]) begin
                data_next[w].x   = up_data[w].x + dx[w];
                data_next[w].y   = up_data[w].y - dy[w];
                data_next[w].acc = up_data[w].acc + ATAN_TURNS[STAGE];
            end else begin
                data_next[w].x   = up_data[w].x - dx[w];
                data_next[w].y   = up_data[w].y + dy[w];
                data_next[w].acc = up_data[w].acc - ATAN_TURNS[STAGE];
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/swdik_scale.sv -----
// Back end: CORDIC gain removal, angle rounding, speed scaling with saturation.
`default_nettype none

module swdik_scale (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire swdik_pkg::vec_row_t up_data,
    input  wire logic [15:0]         inv_radius,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output swdik_pkg::result_t       dn_data
);
    import swdik_pkg::*;

    logic               mag_valid_reg;
    logic               mag_ready;
    logic [MAG_W-1:0]   mag_reg [WHEEL_COUNT];
    logic [MAG_W-1:0]   mag_next [WHEEL_COUNT];
    logic [ANGLE_W-1:0] angle_reg [WHEEL_COUNT];
    logic [ANGLE_W-1:0] angle_next [WHEEL_COUNT];
    logic [PRODM_W-1:0] gain_prod [WHEEL_COUNT];
    logic [ACC_W-1:0]   acc_round [WHEEL_COUNT];

    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;
    logic [PRODM_W-1:0] speed_sum [WHEEL_COUNT];
    logic [PRODM_W-SPEED_SHIFT-1:0] speed_full [WHEEL_COUNT];
    logic [SPEED_W-1:0] speed [WHEEL_COUNT];
    logic               clip [WHEEL_COUNT];

    // Stage one: x never goes negative after the fold, so it is taken as unsigned.
    always_comb begin
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            gain_prod[w]  = PRODM_W'(up_data[w].x[MAG_W-1:0]) * PRODM_W'(INV_GAIN);
            mag_next[w]   = gain_prod[w][PRODM_W-1:GAIN_W];
            acc_round[w]  = up_data[w].acc + ANGLE_ROUND;
            angle_next[w] = up_data[w].zero ? '0 : acc_round[w][ACC_W-1:ACC_W-ANGLE_W];
        end
    end

    assign up_ready = !mag_valid_reg || mag_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
        end else if (up_ready) begin
            mag_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            mag_reg   <= mag_next;
            angle_reg <= angle_next;
        end
    end

    // Stage two: speed rounds half up, then clamps to the top of the range.
    always_comb begin
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            speed_sum[w]  = PRODM_W'(mag_reg[w]) * PRODM_W'(inv_radius) + SPEED_ROUND;
            speed_full[w] = speed_sum[w][PRODM_W-1:SPEED_SHIFT];
            clip[w]       = |speed_full[w][PRODM_W-SPEED_SHIFT-1:SPEED_W];
            speed[w]      = clip[w] ? SPEED_MAX : speed_full[w][SPEED_W-1:0];
        end
        out_next.front_angle   = angle_reg[FRONT];
        out_next.front_speed   = speed[FRONT];
        out_next.rear_angle    = angle_reg[REAR];
        out_next.rear_speed    = speed[REAR];
        out_next.speed_clipped = clip[FRONT] || clip[REAR];
    end

    assign mag_ready = !out_valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mag_ready) begin
            out_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mag_valid_reg && mag_ready) begin
            out_reg <= out_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_data  = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/swerve_drive_inverse_kinematics_top.sv -----
// Top level of the swerve drive inverse kinematics pipeline.
`default_nettype none

// Each item is one body velocity command (vel_x and vel_y in mm/s, yaw_rate in
// Q4.12 rad/s). For the front and rear wheel the block forms the wheel's ground
// velocity vector from the configured wheel offsets, and returns one result item
// holding the steering angle (65536 units per turn, 0 for a zero vector) and the
// wheel speed in Q8.8 rad/s, clamped at 65535 with speed_clipped set. The block
// takes one item per clock cycle when the output side keeps up. The pipeline
// holds two front-end stages, a row of RUN_STAGES identical cells (CORDIC_STAGES
// capped at the table length), each doing one rotation for both wheels, and two
// back-end stages whose last register is the output. Every stage has its own
// valid bit and only stalls when the stage after it is full, so a held result
// does not stop new items from filling the bubbles behind it. The geometry and
// inverse radius registers are written through cfg_we, cfg_index and cfg_wdata
// and must only change while no item is in flight; writes to unknown indexes
// are dropped.
module swerve_drive_inverse_kinematics_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire swdik_pkg::cmd_t        s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output swdik_pkg::result_t          m_data,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [15:0]            cfg_wdata
);
    import swdik_pkg::*;

    // The arctangent table has 24 entries, so longer chains stop there.
    localparam int RUN_STAGES = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    offset_t           front_x_reg;
    offset_t           front_y_reg;
    offset_t           rear_x_reg;
    offset_t           rear_y_reg;
    logic [RADIUS_W-1:0] inv_radius_reg;
    geom_t             geom;

    logic     row_valid [RUN_STAGES+1];
    logic     row_ready [RUN_STAGES+1];
    vec_row_t row_data  [RUN_STAGES+1];

    // Configuration registers, reset to the nominal chassis geometry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_x_reg    <= 12'sd300;
            front_y_reg    <= -12'sd200;
            rear_x_reg     <= -12'sd300;
            rear_y_reg     <= 12'sd200;
            inv_radius_reg <= 16'd655;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRONT_X:    front_x_reg    <= cfg_wdata[OFF_W-1:0];
                CFG_FRONT_Y:    front_y_reg    <= cfg_wdata[OFF_W-1:0];
                CFG_REAR_X:     rear_x_reg     <= cfg_wdata[OFF_W-1:0];
                CFG_REAR_Y:     rear_y_reg     <= cfg_wdata[OFF_W-1:0];
                CFG_INV_RADIUS: inv_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom[FRONT].x = front_x_reg;
        geom[FRONT].y = front_y_reg;
        geom[REAR].x  = rear_x_reg;
        geom[REAR].y  = rear_y_reg;
    end

    // Front end: wheel vectors, zero test and the half-turn fold.
    swdik_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_data  (s_data),
        .geom     (geom),
        .dn_valid (row_valid[0]),
        .dn_ready (row_ready[0]),
        .dn_data  (row_data[0])
    );

    // The CORDIC chain: cell k applies rotation k to both wheels.
    for (genvar k = 0; k < RUN_STAGES; k++) begin : g_cell
        swdik_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (row_valid[k]),
            .up_ready (row_ready[k]),
            .up_data  (row_data[k]),
            .dn_valid (row_valid[k+1]),
            .dn_ready (row_ready[k+1]),
            .dn_data  (row_data[k+1])
        );
    end

    // Back end: magnitude, speed and the output register.
    swdik_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_valid   (row_valid[RUN_STAGES]),
        .up_ready   (row_ready[RUN_STAGES]),
        .up_data    (row_data[RUN_STAGES]),
        .inv_radius (inv_radius_reg),
        .dn_valid   (m_valid),
        .dn_ready   (m_ready),
        .dn_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/swdik_checker.sv -----
// Port-level checks for the swerve drive kinematics block and their binding.
`default_nettype none

module swdik_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire swdik_pkg::result_t m_data
);
    import swdik_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result item changed or vanished while stalled");

    // Nothing is offered right after a reset cycle.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the output side ready, every stage drains, so input is never blocked.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

    // The clip flag only comes with a speed at full scale.
    a_clip_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.speed_clipped) |->
            (m_data.front_speed == SPEED_MAX || m_data.rear_speed == SPEED_MAX))
        else $error("speed clipped without a saturated speed");

endmodule

bind swerve_drive_inverse_kinematics_top swdik_checker u_swdik_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
